### rtl/core/strc_pkg.sv
// Package with types, constants and helper functions of the strobe rate controller.
`timescale 1ns / 1ps

package strc_pkg;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned PERIOD_W = 25;
  localparam int unsigned STEP_W = 3;
  localparam int unsigned TICK_W = 24;
  localparam int unsigned SCALE_W = 8;
  localparam int unsigned ELAPSED_W = 32;
  localparam int unsigned LIMIT_W = SCALE_W + PERIOD_W;
  localparam int unsigned PRODUCT_W = ELAPSED_W + 3;
  localparam int unsigned DIVIDEND_W = 26;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [DIVIDEND_W-1:0] US_PER_MINUTE = 26'd60000000;
  localparam logic [SPEED_W-1:0] SPEED_FLOOR = 16'd10;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = 5'(DIVIDEND_W - 1);

  localparam logic [SCALE_W-1:0] ON_SCALE_RST = 8'd1;
  localparam logic [SCALE_W-1:0] OFF_SCALE_RST = 8'd49;
  localparam logic [TICK_W-1:0] HOLD_TICKS_RST = 24'd60000;
  localparam logic [TICK_W-1:0] COOLDOWN_TICKS_RST = 24'd250000;
  localparam logic [STEP_W-1:0] STEP_RST = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_SCALE = 2'd0,
    REG_OFF_SCALE = 2'd1,
    REG_HOLD_TICKS = 2'd2,
    REG_COOLDOWN_TICKS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_CMP
  } state_t;

  function automatic logic [SPEED_W-1:0] step_amount(input logic [STEP_W-1:0] idx);
    logic [SPEED_W-1:0] amt;
    case (idx)
      3'd1: amt = 16'd1;
      3'd2: amt = 16'd5;
      3'd3: amt = 16'd50;
      3'd4: amt = 16'd500;
      3'd5: amt = 16'd5000;
      default: amt = '0;
    endcase
    return amt;
  endfunction

  function automatic logic [STEP_W-1:0] step_cycle(input logic [STEP_W-1:0] idx);
    logic [STEP_W-1:0] nxt;
    case (idx)
      3'd0: nxt = 3'd1;
      3'd1: nxt = 3'd2;
      3'd2: nxt = 3'd3;
      3'd3: nxt = 3'd4;
      3'd4: nxt = 3'd5;
      3'd5: nxt = 3'd1;
      3'd6: nxt = 3'd2;
      default: nxt = 3'd3;
    endcase
    return nxt;
  endfunction

endpackage

### rtl/core/strobe_rate_controller.sv
// Strobe rate controller: speed setting, period divider and strobe LED timer.
// Sequence: an accepted beat goes from ST_IDLE through ST_MUL to ST_CMP, where its result
// is loaded into the output register; a beat with an encoder click first runs the serial
// divider in ST_DIV, one quotient bit per cycle. A beat is taken only in ST_IDLE, so the
// next beat is taken once the result is loaded, while it waits in the output register.
// Reset: synchronous, active low; clears the speed, period, hold and elapsed timers,
// sets the cooldown timer full, the step index to 3 and the config registers to defaults.
`timescale 1ns / 1ps

module strobe_rate_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // enc_click [0], enc_a [1], enc_b [2], button_down [3], zero fill [7:4]
  input  logic [strc_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // led_on [0], rpm_now [16:1], period_us [41:17], step_select [44:42], zero fill [47:45]
  output logic [strc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [strc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [strc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  strc_pkg::state_t state_r, state_nxt;

  logic [strc_pkg::SCALE_W-1:0]    on_scale_r, off_scale_r;
  logic [strc_pkg::TICK_W-1:0]     hold_ticks_r, cooldown_ticks_r;

  logic [strc_pkg::SPEED_W-1:0]    speed_r, speed_nxt;
  logic [strc_pkg::PERIOD_W-1:0]   period_r, period_nxt;
  logic [strc_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [strc_pkg::TICK_W-1:0]     hold_r, hold_nxt;
  logic [strc_pkg::TICK_W-1:0]     since_r, since_nxt;
  logic                            led_r, led_nxt;
  logic [strc_pkg::ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [strc_pkg::SPEED_W-1:0]    rem_r, rem_nxt;
  logic [strc_pkg::DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [strc_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [strc_pkg::LIMIT_W-1:0]    limit_r, limit_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [strc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic in_fire, click_beat, div_done, led_toggle, out_load;

  logic                            enc_click, enc_a, enc_b, button_down;
  logic [strc_pkg::TICK_W-1:0]     hold_inc, since_inc;
  logic                            pressed;
  logic [strc_pkg::SPEED_W-1:0]    speed_held, speed_moved, amt;
  logic [strc_pkg::SPEED_W:0]      rem_sh;
  logic [strc_pkg::SPEED_W+1:0]    diff;
  logic                            qbit;
  logic [strc_pkg::SCALE_W-1:0]    scale;
  logic [strc_pkg::PRODUCT_W-1:0]  elapsed5;

  assign enc_click   = in_tdata[0];
  assign enc_a       = in_tdata[1];
  assign enc_b       = in_tdata[2];
  assign button_down = in_tdata[3];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_scale_r       <= strc_pkg::ON_SCALE_RST;
      off_scale_r      <= strc_pkg::OFF_SCALE_RST;
      hold_ticks_r     <= strc_pkg::HOLD_TICKS_RST;
      cooldown_ticks_r <= strc_pkg::COOLDOWN_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (strc_pkg::cfg_reg_t'(cfg_index))
        strc_pkg::REG_ON_SCALE:       on_scale_r <= cfg_data[strc_pkg::SCALE_W-1:0];
        strc_pkg::REG_OFF_SCALE:      off_scale_r <= cfg_data[strc_pkg::SCALE_W-1:0];
        strc_pkg::REG_HOLD_TICKS:     hold_ticks_r <= cfg_data;
        strc_pkg::REG_COOLDOWN_TICKS: cooldown_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer outputs.
  always_comb begin
    in_tready  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      strc_pkg::ST_IDLE: in_tready = 1'b1;
      strc_pkg::ST_CMP:  out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign in_fire    = in_tvalid && in_tready;
  assign click_beat = in_fire && enc_click;
  assign div_done   = (state_r == strc_pkg::ST_DIV) && (cnt_r == '0);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      strc_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = enc_click ? strc_pkg::ST_DIV : strc_pkg::ST_MUL;
      end
      strc_pkg::ST_DIV: begin
        if (div_done) state_nxt = strc_pkg::ST_MUL;
      end
      strc_pkg::ST_MUL: state_nxt = strc_pkg::ST_CMP;
      strc_pkg::ST_CMP: begin
        if (out_load) state_nxt = strc_pkg::ST_IDLE;
      end
      default: state_nxt = strc_pkg::ST_IDLE;
    endcase
  end

  // Button, step and encoder update for the accepted beat.
  always_comb begin
    hold_inc  = (button_down && (hold_r != '1)) ? hold_r + 1'b1 : hold_r;
    since_inc = (since_r != '1) ? since_r + 1'b1 : since_r;
    pressed    = 1'b0;
    speed_held = speed_r;
    hold_nxt   = hold_inc;
    if (hold_inc >= hold_ticks_r) begin
      speed_held = 16'd1;
      hold_nxt   = '0;
    end else if ((hold_inc != '0) && !button_down) begin
      pressed  = 1'b1;
      hold_nxt = '0;
    end
    step_nxt  = step_r;
    since_nxt = since_inc;
    if (pressed && (since_inc >= cooldown_ticks_r)) begin
      step_nxt  = strc_pkg::step_cycle(step_r);
      since_nxt = '0;
    end
    amt         = strc_pkg::step_amount(step_nxt);
    speed_moved = (enc_a != enc_b) ? speed_held + amt : speed_held - amt;
    if (speed_moved <= 16'd1) speed_moved = strc_pkg::SPEED_FLOOR;
    speed_nxt   = enc_click ? speed_moved : speed_held;
  end

  // Restoring divider, one quotient bit per cycle, and LED timer datapath.
  always_comb begin
    rem_sh = {rem_r, strc_pkg::US_PER_MINUTE[cnt_r]};
    diff   = {1'b0, rem_sh} - {2'b00, speed_r};
    qbit   = !diff[strc_pkg::SPEED_W+1];
    rem_nxt = qbit ? diff[strc_pkg::SPEED_W-1:0] : rem_sh[strc_pkg::SPEED_W-1:0];
    quo_nxt = {quo_r[strc_pkg::DIVIDEND_W-2:0], qbit};
    cnt_nxt = cnt_r - 1'b1;
    period_nxt = quo_nxt[strc_pkg::PERIOD_W-1:0];

    elapsed_nxt = (elapsed_r != '1) ? elapsed_r + 1'b1 : elapsed_r;

    scale     = led_r ? on_scale_r : off_scale_r;
    limit_nxt = strc_pkg::LIMIT_W'(scale) * strc_pkg::LIMIT_W'(period_r);

    elapsed5   = (strc_pkg::PRODUCT_W'(elapsed_r) << 2) + strc_pkg::PRODUCT_W'(elapsed_r);
    led_toggle = elapsed5 >= strc_pkg::PRODUCT_W'(limit_r);
    led_nxt    = led_toggle ? !led_r : led_r;

    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_data_nxt  = {3'b000, step_r, period_r, speed_r, led_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= strc_pkg::ST_IDLE;
      speed_r     <= '0;
      period_r    <= '0;
      step_r      <= strc_pkg::STEP_RST;
      hold_r      <= '0;
      since_r     <= '1;
      led_r       <= 1'b0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        speed_r   <= speed_nxt;
        step_r    <= step_nxt;
        hold_r    <= hold_nxt;
        since_r   <= since_nxt;
        elapsed_r <= elapsed_nxt;
      end
      if (div_done) period_r <= period_nxt;
      if (out_load) begin
        led_r <= led_nxt;
        if (led_toggle) elapsed_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (click_beat) begin
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= strc_pkg::DIV_LAST_BIT;
    end else if (state_r == strc_pkg::ST_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_nxt;
    end
    if (state_r == strc_pkg::ST_MUL) limit_r <= limit_nxt;
    if (out_load) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
